[sv/vrs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrs_pkg
// Shared constants and codes of the vruntime run queue scheduler.
// ----------------------------------------------------------------------------
package vrs_pkg;

  localparam int DEF_NUM_TASKS = 64;
  localparam int DEF_VR_BITS   = 48;
  localparam int NOW_BITS      = 48;
  localparam int STAMP_BITS    = 16;

  localparam logic [2:0] OP_ADMIT   = 3'd0;
  localparam logic [2:0] OP_WAKE    = 3'd1;
  localparam logic [2:0] OP_SLEEP   = 3'd2;
  localparam logic [2:0] OP_BLOCK   = 3'd3;
  localparam logic [2:0] OP_EXIT    = 3'd4;
  localparam logic [2:0] OP_SCHED   = 3'd5;
  localparam logic [2:0] OP_TICK    = 3'd6;
  localparam logic [2:0] OP_UNKNOWN = 3'd7;

  localparam logic [1:0] RS_RUN    = 2'd0;
  localparam logic [1:0] RS_SLEEP  = 2'd1;
  localparam logic [1:0] RS_BLOCK  = 2'd2;
  localparam logic [1:0] RS_ZOMBIE = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ZOMBIE = 2'd1;
  localparam logic [1:0] ST_QUEUED = 2'd2;

  localparam logic [1:0] CFG_TICK_EN = 2'd0;
  localparam logic [1:0] CFG_GRAN    = 2'd1;
  localparam logic [1:0] CFG_IDLE    = 2'd2;

  localparam logic [7:0] GRAN_RESET = 8'd2;

endpackage
`default_nettype wire

[sv/vruntime_run_queue_scheduler_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vruntime_run_queue_scheduler_unit
// Single-CPU fair scheduler over a rotating chain of task slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a request by raising start with op, task_id and now; it is taken at
//   an edge where busy is low. Exactly one result follows, shown for one cycle
//   with result_valid high; the receiver cannot stall, so sample it then.
//   Configuration writes use cfg_valid/cfg_ready (always ready) with
//   cfg_index 0 tick_enable, 1 granularity, 2 idle_task; write only while idle.
// Operation:
//   The task table is a ring of NUM_TASKS cells that rotates one slot per
//   cycle while a pass runs, past a single head processing stage. Wake,
//   sleep, block, exit and enabled tick take one pass; admit and schedule
//   take two (gather, then write back). Unknown ops, disabled ticks and
//   out-of-range slots answer without a pass.
// Reset:
//   rst (synchronous) clears every slot but its stamp, selects the idle slot as current,
//   and restores the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module vruntime_run_queue_scheduler_unit
  import vrs_pkg::*;
#(
  parameter int NUM_TASKS     = DEF_NUM_TASKS,
  parameter int VRUNTIME_BITS = DEF_VR_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [2:0]          op,
  input  wire logic [5:0]          task_id,
  input  wire logic [NOW_BITS-1:0] now,
  output logic                     result_valid,
  output logic      [5:0]          running_task,
  output logic                     resched_req,
  output logic      [6:0]          queued,
  output logic      [1:0]          status,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data
);

  localparam int SW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW = $clog2(NUM_TASKS + 1);
  localparam int VB = VRUNTIME_BITS;

  typedef enum logic [1:0] {S_IDLE, S_PASS_A, S_PASS_B} state_t;

  state_t state;

  // configuration
  logic       tick_en;
  logic [7:0] gran;
  logic [5:0] idle_cfg;

  // global scheduler state
  logic [SW-1:0]         cur;
  logic                  resched;
  logic [STAMP_BITS-1:0] sc;
  logic [CW-1:0]         count;

  // latched request
  logic [2:0]          op_r;
  logic [SW-1:0]       t_r;
  logic [NOW_BITS-1:0] now_r;
  logic [SW-1:0]       idle_r;
  logic [SW-1:0]       idx;
  logic [1:0]          status_r;

  // values gathered during the first pass
  logic [VB-1:0]         g_cur_vr, g_cur_vr_next;
  logic [1:0]            g_cur_rs, g_cur_rs_next;
  logic                  g_cur_inq, g_cur_inq_next;
  logic                  g_t_inq, g_t_inq_next;
  logic                  best_found, best_found_next;
  logic [SW-1:0]         best_idx, best_idx_next;
  logic [VB-1:0]         best_vr, best_vr_next;
  logic [STAMP_BITS-1:0] best_age, best_age_next;

  // schedule decision, held for the write-back pass
  logic [SW-1:0] sched_sel;
  logic          sched_found;
  logic          sched_enq;

  // ring of cells
  logic [VB-1:0]         vr_q     [NUM_TASKS];
  logic [1:0]            rs_q     [NUM_TASKS];
  logic                  inq_q    [NUM_TASKS];
  logic [STAMP_BITS-1:0] stamp_q  [NUM_TASKS];
  logic [NOW_BITS-1:0]   rstart_q [NUM_TASKS];

  // head write-back into the tail cell
  logic [VB-1:0]         w_vr;
  logic [1:0]            w_rs;
  logic                  w_inq;
  logic [STAMP_BITS-1:0] w_stamp;
  logic [NOW_BITS-1:0]   w_rstart;

  logic shift_en;
  assign shift_en = (state == S_PASS_A) || (state == S_PASS_B);

  for (genvar k = 0; k < NUM_TASKS; k++) begin : g_ring
    if (k == NUM_TASKS - 1) begin : g_tail
      vrs_cell #(.VB(VB)) u_cell (
        .clk(clk), .rst(rst), .shift_en(shift_en),
        .vr_d(w_vr), .rs_d(w_rs), .inq_d(w_inq), .stamp_d(w_stamp), .rstart_d(w_rstart),
        .vr_q(vr_q[k]), .rs_q(rs_q[k]), .inq_q(inq_q[k]), .stamp_q(stamp_q[k]),
        .rstart_q(rstart_q[k])
      );
    end else begin : g_body
      vrs_cell #(.VB(VB)) u_cell (
        .clk(clk), .rst(rst), .shift_en(shift_en),
        .vr_d(vr_q[k+1]), .rs_d(rs_q[k+1]), .inq_d(inq_q[k+1]),
        .stamp_d(stamp_q[k+1]), .rstart_d(rstart_q[k+1]),
        .vr_q(vr_q[k]), .rs_q(rs_q[k]), .inq_q(inq_q[k]), .stamp_q(stamp_q[k]),
        .rstart_q(rstart_q[k])
      );
    end
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // request decode at acceptance
  logic          accept;
  logic          t_valid;
  logic [SW-1:0] t_in;
  logic [SW-1:0] idle_in;
  logic          slot_op;
  logic          skip;

  assign accept  = start && !busy;
  assign t_valid = (32'(task_id) < NUM_TASKS);
  assign t_in    = SW'(task_id);
  assign idle_in = (32'(idle_cfg) < NUM_TASKS) ? SW'(idle_cfg) : '0;
  assign slot_op = (op == OP_ADMIT) || (op == OP_WAKE) || (op == OP_SLEEP) || (op == OP_BLOCK);
  assign skip    = (op == OP_UNKNOWN) || ((op == OP_TICK) && !tick_en) || (slot_op && !t_valid);

  // head stage
  logic                  last;
  logic                  hit_t;
  logic                  hit_cur;
  logic [STAMP_BITS-1:0] h_age;
  logic [NOW_BITS-1:0]   delta;
  logic [VB-1:0]         tick_vr;
  logic                  admit_do;
  logic [CW-1:0]         count_next;
  logic [STAMP_BITS-1:0] sc_next;
  logic [1:0]            status_next;
  logic [SW-1:0]         sel_next;
  logic                  enq_next;
  logic [VB-1:0]         lead;
  logic                  preempt;

  assign last     = (idx == SW'(NUM_TASKS - 1));
  assign hit_t    = (idx == t_r);
  assign hit_cur  = (idx == cur);
  assign h_age    = sc - stamp_q[0];
  assign delta    = now_r - rstart_q[0];
  assign tick_vr  = vr_q[0] + VB'(delta);
  assign admit_do = !g_t_inq && (t_r != cur) && (t_r != idle_r);

  always_comb begin
    w_vr            = vr_q[0];
    w_rs            = rs_q[0];
    w_inq           = inq_q[0];
    w_stamp         = stamp_q[0];
    w_rstart        = rstart_q[0];
    count_next      = count;
    sc_next         = sc;
    status_next     = status_r;
    g_cur_vr_next   = g_cur_vr;
    g_cur_rs_next   = g_cur_rs;
    g_cur_inq_next  = g_cur_inq;
    g_t_inq_next    = g_t_inq;
    best_found_next = best_found;
    best_idx_next   = best_idx;
    best_vr_next    = best_vr;
    best_age_next   = best_age;
    if (state == S_PASS_A) begin
      if (hit_cur) begin
        g_cur_vr_next  = vr_q[0];
        g_cur_rs_next  = rs_q[0];
        g_cur_inq_next = inq_q[0];
      end
      if (hit_t) begin
        g_t_inq_next = inq_q[0];
      end
      // running minimum, ties to the oldest insertion
      if (inq_q[0]) begin
        if (!best_found || (vr_q[0] < best_vr) ||
            ((vr_q[0] == best_vr) && (h_age > best_age))) begin
          best_found_next = 1'b1;
          best_idx_next   = idx;
          best_vr_next    = vr_q[0];
          best_age_next   = h_age;
        end
      end
      unique case (op_r)
        OP_ADMIT: begin
          if (hit_t && inq_q[0]) begin
            status_next = ST_QUEUED;
          end
        end
        OP_WAKE: begin
          if (hit_t) begin
            if (rs_q[0] == RS_ZOMBIE) begin
              status_next = ST_ZOMBIE;
            end else if (rs_q[0] != RS_RUN) begin
              w_rs = RS_RUN;
              if (!inq_q[0] && (t_r != cur) && (t_r != idle_r)) begin
                w_inq      = 1'b1;
                w_stamp    = sc;
                sc_next    = sc + 1'b1;
                count_next = count + 1'b1;
              end
            end
          end
        end
        OP_SLEEP, OP_BLOCK: begin
          if (hit_t && (rs_q[0] == RS_RUN)) begin
            w_rs = (op_r == OP_SLEEP) ? RS_SLEEP : RS_BLOCK;
            if (inq_q[0]) begin
              w_inq      = 1'b0;
              count_next = count - 1'b1;
            end
          end
        end
        OP_EXIT: begin
          if (hit_cur) begin
            w_rs = RS_ZOMBIE;
            if (inq_q[0]) begin
              w_inq      = 1'b0;
              count_next = count - 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (hit_cur && (rs_q[0] == RS_RUN) && (delta != '0)) begin
            w_rstart      = now_r;
            w_vr          = tick_vr;
            g_cur_vr_next = tick_vr;
          end
        end
        default: ;
      endcase
    end else if (state == S_PASS_B) begin
      unique case (op_r)
        OP_ADMIT: begin
          if (hit_t && admit_do) begin
            w_rs       = RS_RUN;
            w_vr       = g_cur_vr + VB'(gran);
            w_inq      = 1'b1;
            w_stamp    = sc;
            sc_next    = sc + 1'b1;
            count_next = count + 1'b1;
          end
        end
        OP_SCHED: begin
          if (idx == sched_sel) begin
            if (sched_found) begin
              w_inq      = 1'b0;
              count_next = count - 1'b1;
            end
            if (sched_sel != cur) begin
              w_rstart = now_r;
            end
          end else if (hit_cur && sched_enq) begin
            w_inq      = 1'b1;
            w_stamp    = sc;
            sc_next    = sc + 1'b1;
            count_next = count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // end-of-gather decisions
  always_comb begin
    if (best_found_next) begin
      sel_next = best_idx_next;
    end else begin
      sel_next = (g_cur_rs_next == RS_RUN) ? cur : idle_r;
    end
    enq_next = (sel_next != cur) && (g_cur_rs_next == RS_RUN) && (cur != idle_r) &&
               !g_cur_inq_next;
    lead     = g_cur_vr_next - best_vr_next;
    preempt  = best_found_next && (best_idx_next != cur) && !lead[VB-1] &&
               (lead > VB'(gran));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tick_en      <= 1'b0;
      gran         <= GRAN_RESET;
      idle_cfg     <= '0;
      cur          <= '0;
      resched      <= 1'b0;
      sc           <= '0;
      count        <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
      best_found   <= 1'b0;
      status_r     <= ST_OK;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_TICK_EN: tick_en  <= cfg_data[0];
          CFG_GRAN:    gran     <= cfg_data;
          CFG_IDLE:    idle_cfg <= cfg_data[5:0];
          default: ;
        endcase
      end
      g_cur_vr   <= g_cur_vr_next;
      g_cur_rs   <= g_cur_rs_next;
      g_cur_inq  <= g_cur_inq_next;
      g_t_inq    <= g_t_inq_next;
      best_found <= best_found_next;
      best_idx   <= best_idx_next;
      best_vr    <= best_vr_next;
      best_age   <= best_age_next;
      status_r   <= status_next;
      sc         <= sc_next;
      count      <= count_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_r       <= op;
            t_r        <= t_in;
            now_r      <= now;
            idle_r     <= idle_in;
            idx        <= '0;
            best_found <= 1'b0;
            status_r   <= ST_OK;
            if (skip) begin
              // answer at once with the unchanged state
              result_valid <= 1'b1;
              running_task <= 6'(cur);
              resched_req  <= resched;
              queued       <= 7'(count);
              status       <= ST_OK;
            end else begin
              state <= S_PASS_A;
            end
          end
        end
        S_PASS_A: begin
          idx <= last ? '0 : idx + 1'b1;
          if (last) begin
            sched_sel   <= sel_next;
            sched_found <= best_found_next;
            sched_enq   <= enq_next;
            if ((op_r == OP_ADMIT) || (op_r == OP_SCHED)) begin
              state <= S_PASS_B;
            end else begin
              state        <= S_IDLE;
              result_valid <= 1'b1;
              running_task <= 6'(cur);
              resched_req  <= resched || ((op_r == OP_TICK) && preempt);
              queued       <= 7'(count_next);
              status       <= status_next;
              if ((op_r == OP_TICK) && preempt) begin
                resched <= 1'b1;
              end
            end
          end
        end
        S_PASS_B: begin
          idx <= last ? '0 : idx + 1'b1;
          if (last) begin
            state        <= S_IDLE;
            result_valid <= 1'b1;
            queued       <= 7'(count_next);
            status       <= status_r;
            if (op_r == OP_SCHED) begin
              cur          <= sched_sel;
              resched      <= 1'b0;
              running_task <= 6'(sched_sel);
              resched_req  <= 1'b0;
            end else begin
              running_task <= 6'(cur);
              resched_req  <= resched;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // a result is only shown once the ring is at rest
  assert property (@(posedge clk) disable iff (rst) !(result_valid && busy))
    else $error("result shown while a pass is running");
  // queue occupancy never exceeds the slot count
  assert property (@(posedge clk) disable iff (rst) (32'(count) <= NUM_TASKS))
    else $error("queue count out of range");
  // the ring is back in place whenever the block is idle
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> (idx == '0))
    else $error("ring misaligned at rest");
  // the current slot always names a real slot
  assert property (@(posedge clk) disable iff (rst) (32'(cur) < NUM_TASKS))
    else $error("current slot out of range");
`endif

endmodule
`default_nettype wire

[sv/vrs_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vrs_cell
// One task slot of the rotating chain; takes its neighbour's slot on shift.
// ----------------------------------------------------------------------------
module vrs_cell
  import vrs_pkg::*;
#(
  parameter int VB = DEF_VR_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  shift_en,
  input  wire logic [VB-1:0]         vr_d,
  input  wire logic [1:0]            rs_d,
  input  wire logic                  inq_d,
  input  wire logic [STAMP_BITS-1:0] stamp_d,
  input  wire logic [NOW_BITS-1:0]   rstart_d,
  output logic      [VB-1:0]         vr_q,
  output logic      [1:0]            rs_q,
  output logic                       inq_q,
  output logic      [STAMP_BITS-1:0] stamp_q,
  output logic      [NOW_BITS-1:0]   rstart_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      vr_q     <= '0;
      rs_q     <= RS_RUN;
      inq_q    <= 1'b0;
      rstart_q <= '0;
    end else if (shift_en) begin
      vr_q     <= vr_d;
      rs_q     <= rs_d;
      inq_q    <= inq_d;
      rstart_q <= rstart_d;
    end
  end

  // stamp is only read for queued slots, so it needs no reset
  always_ff @(posedge clk) begin
    if (shift_en) begin
      stamp_q <= stamp_d;
    end
  end

endmodule
`default_nettype wire

[bench/vruntime_run_queue_scheduler_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vruntime_run_queue_scheduler_unit_tb
// Self-checking bench for the fair scheduler. A predictor holds its own copy
// of the task table and registers. It works out the result of every accepted
// request, and each strobed result is compared field by field against the
// oldest prediction. Directed events come first, then random event streams
// under several register settings, with random gaps in issue.
// ----------------------------------------------------------------------------
module vruntime_run_queue_scheduler_unit_tb;
  import vrs_pkg::*;

  localparam int SLOTS      = DEF_NUM_TASKS;
  localparam int IDLE_LIMIT = 5000;  // cycles with no handshake before giving up

  typedef struct packed {
    logic [5:0] run_slot;
    logic       resched;
    logic [6:0] depth;
    logic [1:0] code;
  } sched_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: scheduler predictor plus the store of predicted results
  // --------------------------------------------------------------------------
  class sched_scoreboard;
    logic [47:0]   vrun[SLOTS];
    logic [1:0]    rstate[SLOTS];
    bit            queued_flag[SLOTS];
    logic [15:0]   stamp[SLOTS];
    logic [47:0]   started[SLOTS];
    logic [5:0]    cur_slot;
    bit            resched;
    logic [15:0]   stamp_ctr;
    int            depth;
    bit            tick_en;
    logic [7:0]    gran;
    logic [5:0]    idle_slot;
    sched_result_t pending_results[$];
    int            mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        vrun[i] = '0; rstate[i] = RS_RUN; queued_flag[i] = 0;
        stamp[i] = '0; started[i] = '0;
      end
      tick_en = 0; gran = GRAN_RESET; idle_slot = '0;
      cur_slot = '0; resched = 0; stamp_ctr = '0; depth = 0; mismatches = 0;
    endfunction

    task report(string msg);
      $display("%0t MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    function void write_reg(logic [1:0] idx, logic [7:0] data);
      case (idx)
        CFG_TICK_EN: tick_en = data[0];
        CFG_GRAN:    gran = data;
        CFG_IDLE:    idle_slot = data[5:0];
        default: ;
      endcase
    endfunction

    function void push_slot(int t);
      queued_flag[t] = 1;
      stamp[t] = stamp_ctr;
      stamp_ctr++;
      depth++;
    endfunction

    function void pull_slot(int t);
      if (queued_flag[t]) begin
        queued_flag[t] = 0;
        depth--;
      end
    endfunction

    // Least vruntime among queued slots, ties to the oldest insertion
    function int least_vruntime_slot();
      int best;
      logic [15:0] age_i, age_b;
      best = SLOTS;
      for (int i = 0; i < SLOTS; i++) begin
        if (!queued_flag[i]) continue;
        if (best == SLOTS || vrun[i] < vrun[best]) best = i;
        else if (vrun[i] == vrun[best]) begin
          age_i = stamp_ctr - stamp[i];
          age_b = stamp_ctr - stamp[best];
          if (age_i > age_b) best = i;
        end
      end
      return best;
    endfunction

    // Predict the result of one accepted request and store it
    function void note_request(logic [2:0] kind, logic [5:0] t, logic [47:0] at);
      int cur, nxt, lm;
      logic [1:0] code;
      logic [47:0] delta, lead;
      sched_result_t r;
      cur = cur_slot;
      code = ST_OK;
      case (kind)
        OP_ADMIT: begin
          if (queued_flag[t]) code = ST_QUEUED;
          else if (t != cur && t != idle_slot) begin
            rstate[t] = RS_RUN;
            vrun[t] = vrun[cur] + 48'(gran);
            push_slot(t);
          end
        end
        OP_WAKE: begin
          if (rstate[t] == RS_ZOMBIE) code = ST_ZOMBIE;
          else if (rstate[t] != RS_RUN) begin
            rstate[t] = RS_RUN;
            if (!queued_flag[t] && t != cur && t != idle_slot) push_slot(t);
          end
        end
        OP_SLEEP, OP_BLOCK: begin
          if (rstate[t] == RS_RUN) begin
            pull_slot(t);
            rstate[t] = (kind == OP_SLEEP) ? RS_SLEEP : RS_BLOCK;
          end
        end
        OP_EXIT: begin
          rstate[cur] = RS_ZOMBIE;
          pull_slot(cur);
        end
        OP_SCHED: begin
          nxt = least_vruntime_slot();
          if (nxt == SLOTS) nxt = (rstate[cur] == RS_RUN) ? cur : idle_slot;
          else pull_slot(nxt);
          if (nxt != cur) begin
            if (rstate[cur] == RS_RUN && cur != idle_slot && !queued_flag[cur])
              push_slot(cur);
            cur = nxt;
            started[cur] = at;
          end
          resched = 0;
        end
        OP_TICK: begin
          if (tick_en) begin
            if (rstate[cur] == RS_RUN) begin
              delta = at - started[cur];
              if (delta != 0) begin
                started[cur] = at;
                vrun[cur] = vrun[cur] + delta;
              end
            end
            lm = least_vruntime_slot();
            if (lm != SLOTS && lm != cur) begin
              lead = vrun[cur] - vrun[lm];
              if (!lead[47] && lead > 48'(gran)) resched = 1;
            end
          end
        end
        default: ;
      endcase
      cur_slot = cur;
      r.run_slot = cur_slot;
      r.resched  = resched;
      r.depth    = depth[6:0];
      r.code     = code;
      pending_results.push_back(r);
    endfunction

    task check_result(sched_result_t got);
      sched_result_t want;
      if (pending_results.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      want = pending_results.pop_front();
      if (got.run_slot !== want.run_slot)
        report($sformatf("running_task %0d, predicted %0d", got.run_slot, want.run_slot));
      if (got.resched !== want.resched)
        report($sformatf("resched_req %0b, predicted %0b", got.resched, want.resched));
      if (got.depth !== want.depth)
        report($sformatf("queued %0d, predicted %0d", got.depth, want.depth));
      if (got.code !== want.code)
        report($sformatf("status %0d, predicted %0d", got.code, want.code));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [2:0]  op = '0;
  logic [5:0]  task_id = '0;
  logic [47:0] now = '0;
  logic        result_valid;
  logic [5:0]  running_task;
  logic        resched_req;
  logic [6:0]  queued;
  logic [1:0]  status;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  vruntime_run_queue_scheduler_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .task_id(task_id),
    .now(now), .result_valid(result_valid), .running_task(running_task),
    .resched_req(resched_req), .queued(queued), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  sched_scoreboard sb = new();
  int          quiet_cycles = 0;
  logic [47:0] tick_clock = '0;  // running time base for the random streams

  // --------------------------------------------------------------------------
  // Monitor: every handshake is sampled on the edge that completes it
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      // note the request first so a same-edge result still pops the older one
      if (start && !busy) begin
        sb.note_request(op, task_id, now);
        moved = 1'b1;
      end
      if (result_valid) begin
        sb.check_result('{running_task, resched_req, queued, status});
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        moved = 1'b1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog: give up when nothing moves for too long
  always @(posedge clk) begin
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Mostly short gaps, now and then a long one; zero keeps start high
  function automatic int pick_gap(bit busy_phase);
    if (busy_phase) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 3);
  endfunction

  // Present one request and hold it until the block takes it
  task automatic issue(logic [2:0] kind, logic [5:0] t, logic [47:0] at, int gap);
    start   <= 1;
    op      <= kind;
    task_id <= t;
    now     <= at;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain every outstanding result, then let the block settle
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Hold a write until it is taken; the caller drops valid after the last one
  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(bit en, logic [7:0] g, logic [5:0] idle);
    write_reg(CFG_TICK_EN, 8'(en));
    write_reg(CFG_GRAN, g);
    write_reg(CFG_IDLE, 8'(idle));
    cfg_valid <= 0;
  endtask

  // Random event stream: weighted random ops over a small pool of slots,
  // with occasional wide slot numbers, wild timestamps and unknown ops
  task automatic random_events(int count);
    logic [2:0]  kind;
    logic [5:0]  t;
    logic [47:0] at;
    int          w;
    bit          no_gaps;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      w = $urandom_range(0, 99);
      if (w < 20)      kind = OP_ADMIT;
      else if (w < 33) kind = OP_WAKE;
      else if (w < 42) kind = OP_SLEEP;
      else if (w < 47) kind = OP_BLOCK;
      else if (w < 51) kind = OP_EXIT;
      else if (w < 72) kind = OP_SCHED;
      else if (w < 98) kind = OP_TICK;
      else             kind = OP_UNKNOWN;
      t = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 11));
      w = $urandom_range(0, 99);
      if (w < 3) begin
        tick_clock = {16'($urandom), 32'($urandom)};
      end else if (w < 5) begin
        tick_clock = tick_clock - 48'($urandom_range(1, 20));  // time running backwards
      end else begin
        tick_clock = tick_clock + 48'($urandom_range(0, 9));
      end
      at = tick_clock;
      issue(kind, t, at, pick_gap(no_gaps));
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [5:0] victim;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Defaults: ticks ignored; admit paths, duplicate admit, idle admit
    issue(OP_TICK,    6'd0,  48'd5, 0);
    issue(OP_ADMIT,   6'd1,  48'd0, 1);
    issue(OP_ADMIT,   6'd2,  48'd0, 0);
    issue(OP_ADMIT,   6'd63, 48'd0, 2);
    issue(OP_ADMIT,   6'd2,  48'd0, 0);
    issue(OP_ADMIT,   6'd0,  48'd0, 0);
    issue(OP_UNKNOWN, 6'd21, 48'hFFFF_FFFF_FFFF, 0);
    issue(OP_SCHED,   6'd42, 48'd0, 3);
    drain();

    // Ticks on, zero granularity: charge, preempt, state changes
    apply_settings(1'b1, 8'd0, 6'd0);
    issue(OP_TICK,  6'd0,  48'd10, 0);
    issue(OP_TICK,  6'd0,  48'hFFFF_FFFF_FFFF, 0);
    issue(OP_SCHED, 6'd0,  48'd20, 0);
    issue(OP_SLEEP, 6'd63, 48'd21, 0);
    issue(OP_BLOCK, 6'd2,  48'd22, 0);
    issue(OP_WAKE,  6'd2,  48'd23, 0);
    issue(OP_WAKE,  6'd63, 48'd24, 0);
    drain();
    victim = sb.cur_slot;
    issue(OP_EXIT,  6'd0,  48'd25, 0);
    issue(OP_WAKE,  victim, 48'd26, 0);
    issue(OP_SCHED, 6'd0,  48'd27, 0);
    issue(OP_SCHED, 6'd0,  48'd28, 0);
    issue(OP_SCHED, 6'd0,  48'd29, 0);
    issue(OP_SCHED, 6'd0,  48'd30, 0);
    drain();

    // Random streams under a spread of settings, extremes included
    tick_clock = 48'd100;
    apply_settings(1'b1, 8'd2,   6'd0);  random_events(230); drain();
    apply_settings(1'b1, 8'd0,   6'd5);  random_events(230); drain();
    apply_settings(1'b1, 8'd255, 6'd63); random_events(230); drain();
    apply_settings(1'b0, 8'd7,   6'd1);  random_events(200); drain();
    apply_settings(1'b1, 8'd1,   6'd0);  random_events(230); drain();
    apply_settings(1'b1, 8'd128, 6'd17); random_events(230); drain();

    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/vrs_pkg.sv
sv/vrs_cell.sv
sv/vruntime_run_queue_scheduler_unit.sv
bench/vruntime_run_queue_scheduler_unit_tb.sv
